### sv/mexp_pkg.sv
// Package for the modular exponentiation unit: field widths, reset value of
// the modulus, sequencer and multiplier state types.
// No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int unsigned ValW   = 31;
  localparam int unsigned ExpW   = 63;
  localparam int unsigned ProdW  = 2 * ValW;
  // two remainder bits retired per reduction cycle
  localparam int unsigned RedCyc = ProdW / 2;
  localparam int unsigned CntW   = $clog2(RedCyc);

  localparam logic [ValW-1:0] ModReset = 31'd1000000007;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CHECK,
    SEQ_WAIT_MUL,
    SEQ_WAIT_SQR
  } seq_state_t;

  typedef enum logic [0:0] {
    MM_IDLE,
    MM_RED
  } mm_state_t;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_sts_t;

endpackage

`default_nettype wire

### sv/mexp_mulmod.sv
// Shared modular multiplier: one registered 31x31 product, then a restoring
// reduction two bits a cycle.
// Depends on mexp_pkg.
`default_nettype none

module mexp_mulmod
  import mexp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire logic [ValW-1:0] op_a,
  input  wire logic [ValW-1:0] op_b,
  input  wire logic [ValW:0]   mod32,
  output mm_sts_t              sts,
  output logic      [ValW-1:0] result
);

  mm_state_t        state_r, state_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [ProdW-1:0] prod_r, prod_nxt;
  logic [ValW-1:0]  rem_r, rem_nxt;
  logic [ProdW-1:0] prod_w;
  logic [ValW-1:0]  rem_mid;
  logic [ValW-1:0]  rem_fin;

  // shift one product bit into the remainder and subtract the modulus at most once;
  // remainder stays below the modulus, so one subtract is enough
  function automatic logic [ValW-1:0] red_step(input logic [ValW-1:0] r,
                                               input logic            b,
                                               input logic [ValW:0]   m);
    logic [ValW:0] t;
    t = {r, b};
    if (t >= m) begin
      t = t - m;
    end
    return t[ValW-1:0];
  endfunction

  assign prod_w  = ProdW'(op_a) * ProdW'(op_b);
  assign rem_mid = red_step(rem_r, prod_r[ProdW-1], mod32);
  assign rem_fin = red_step(rem_mid, prod_r[ProdW-2], mod32);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    case (state_r)
      MM_IDLE: begin
        if (go) begin
          prod_nxt  = prod_w;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = MM_RED;
        end
      end
      MM_RED: begin
        rem_nxt  = rem_fin;
        prod_nxt = {prod_r[ProdW-3:0], 2'b00};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CntW'(RedCyc - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = MM_IDLE;
        end
      end
      default: begin
        state_nxt = MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign sts.busy = (state_r != MM_IDLE);
  assign sts.done = done_r;
  assign result   = rem_r;

endmodule

`default_nettype wire

### sv/modular_exponentiation_unit.sv
// Modular exponentiation unit: right-to-left square-and-multiply sequencer
// around one shared modular multiplier. Depends on mexp_pkg, mexp_mulmod.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  input    | in_base_value, in_exponent              | start high, busy low
//  result   | out_power_result                        | out_strobe, one cycle
//  config   | cfg_modulus                             | cfg_valid and cfg_ready
//
// Each modular product is launched from the sequencer, reduced in the shared
// multiplier and handed back on its done flag; the 31x31 multiply sits in the
// launch cycle. Each exponent bit also passes through the check state, and a zero
// base or zero exponent ends the item at its first check. One item at a time: busy
// stays high until the result word is shown. The receiver cannot stall.
// Reset sets the modulus to 1000000007 and clears the sequencer.
`default_nettype none

module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [ValW-1:0] in_base_value,
  input  wire logic [ExpW-1:0] in_exponent,
  output logic                 out_strobe,
  output logic      [ValW-1:0] out_power_result,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [ValW-1:0] cfg_modulus
);

  seq_state_t      state_r, state_nxt;
  logic [ValW-1:0] modulus_r;
  logic [ValW-1:0] acc_r, acc_nxt;
  logic [ValW-1:0] sq_r, sq_nxt;
  logic [ExpW-1:0] exp_r, exp_nxt;
  logic            bz_r, bz_nxt;
  logic            strobe_r, strobe_nxt;
  logic [ValW-1:0] res_r, res_nxt;
  logic            mm_go;
  logic            mul_sel;
  logic [ValW-1:0] op_a;
  logic [ValW:0]   mod32;
  mm_sts_t         mm_sts;
  logic [ValW-1:0] mm_res;

  // a modulus of zero stands for 2^31
  assign mod32 = {(modulus_r == '0), modulus_r};
  assign op_a  = mul_sel ? acc_r : sq_r;

  mexp_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (mm_go),
    .op_a   (op_a),
    .op_b   (sq_r),
    .mod32  (mod32),
    .sts    (mm_sts),
    .result (mm_res)
  );

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    sq_nxt     = sq_r;
    exp_nxt    = exp_r;
    bz_nxt     = bz_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    mm_go      = 1'b0;
    mul_sel    = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          acc_nxt   = ValW'(1);
          sq_nxt    = in_base_value;
          exp_nxt   = in_exponent;
          bz_nxt    = (in_base_value == '0);
          state_nxt = SEQ_CHECK;
        end
      end
      SEQ_CHECK: begin
        if (exp_r == '0 || bz_r) begin
          strobe_nxt = 1'b1;
          res_nxt    = bz_r ? '0 : acc_r;
          state_nxt  = SEQ_IDLE;
        end else if (exp_r[0]) begin
          mm_go     = 1'b1;
          mul_sel   = 1'b1;
          state_nxt = SEQ_WAIT_MUL;
        end else begin
          mm_go     = 1'b1;
          state_nxt = SEQ_WAIT_SQR;
        end
      end
      SEQ_WAIT_MUL: begin
        if (mm_sts.done) begin
          acc_nxt = mm_res;
          // squares past the top set bit never reach the product
          if (exp_r[ExpW-1:1] == '0) begin
            exp_nxt   = '0;
            state_nxt = SEQ_CHECK;
          end else begin
            mm_go     = 1'b1;
            state_nxt = SEQ_WAIT_SQR;
          end
        end
      end
      SEQ_WAIT_SQR: begin
        if (mm_sts.done) begin
          sq_nxt    = mm_res;
          exp_nxt   = {1'b0, exp_r[ExpW-1:1]};
          state_nxt = SEQ_CHECK;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SEQ_IDLE;
      strobe_r  <= 1'b0;
      modulus_r <= ModReset;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_modulus;
      end
    end
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    exp_r <= exp_nxt;
    bz_r  <= bz_nxt;
    res_r <= res_nxt;
  end

  assign busy             = (state_r != SEQ_IDLE);
  assign cfg_ready        = (state_r == SEQ_IDLE);
  assign out_strobe       = strobe_r;
  assign out_power_result = res_r;

  a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mm_go |-> !mm_sts.busy)
    else $error("multiplier launched while busy");

  a_busy_ends_with_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result word");

  a_word_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result word without an item");

  a_word_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_power_result} < mod32 || out_power_result == ValW'(1)))
    else $error("result word not reduced");

endmodule

`default_nettype wire

### bench/modular_exponentiation_unit_tb.sv
// Self-checking bench for modular_exponentiation_unit: directed table, then random
// phases under several moduli; results not fixed in the table come from a
// square-and-multiply model. Depends on mexp_pkg and the unit itself.
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;
  import mexp_pkg::*;

  localparam logic [ValW-1:0] MaxVal    = {ValW{1'b1}};
  localparam logic [ExpW-1:0] MaxExp    = {ExpW{1'b1}};
  localparam int              NumRows   = 24;
  localparam int              NumPhases = 10;
  localparam int              PhaseLen  = 145;
  localparam int              StallMax  = 20000;

  typedef struct packed {
    logic            wr_mod;
    logic [ValW-1:0] mod_val;
    logic [ValW-1:0] base;
    logic [ExpW-1:0] expo;
    logic            known;
    logic [ValW-1:0] want;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [ValW-1:0] in_base_value = '0;
  logic [ExpW-1:0] in_exponent = '0;
  logic            out_strobe;
  logic [ValW-1:0] out_power_result;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [ValW-1:0] cfg_modulus = '0;

  logic [ValW-1:0] pending_powers[$];
  logic [ValW-1:0] model_modulus = ModReset;
  int              mismatches = 0;
  int              stall_cycles = 0;
  dir_row_t        dir_rows[NumRows];

  modular_exponentiation_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_base_value   (in_base_value),
    .in_exponent     (in_exponent),
    .out_strobe      (out_strobe),
    .out_power_result(out_power_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_modulus     (cfg_modulus)
  );

  always #10 clk = ~clk;

  // a modulus of zero stands for 2^31: keep the low 31 bits
  function automatic logic [63:0] fold_mod(input logic [63:0] p, input logic [ValW-1:0] m);
    if (m == '0) begin
      return p & {33'd0, MaxVal};
    end
    return p % {33'd0, m};
  endfunction

  function automatic logic [ValW-1:0] modpow_predict(input logic [ValW-1:0] b,
                                                     input logic [ExpW-1:0] e,
                                                     input logic [ValW-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    int          i;
    acc = 64'd1;
    sq  = {33'd0, b};
    for (i = 0; i < ExpW; i++) begin
      if (e[i]) begin
        acc = fold_mod(acc * sq, m);
      end
      sq = fold_mod(sq * sq, m);
    end
    // base not reduced up front; zero exponent gives an unreduced 1
    return (b != '0) ? acc[ValW-1:0] : '0;
  endfunction

  function automatic logic [ValW-1:0] draw_base();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      return '0;
    end
    if (pick < 14) begin
      return ValW'(1);
    end
    if (pick < 22) begin
      return MaxVal - ValW'($urandom_range(0, 3));
    end
    if (pick < 45) begin
      return ValW'($urandom_range(2, 1000));
    end
    return ValW'($urandom);
  endfunction

  // mostly short exponents to keep the run short; a few at full width
  function automatic logic [ExpW-1:0] draw_exponent();
    int unsigned pick;
    int unsigned w;
    logic [63:0] raw;
    pick = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    if (pick < 8) begin
      return '0;
    end
    if (pick < 13) begin
      return ExpW'(raw);
    end
    w = (pick < 38) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    return ExpW'(raw & ((64'd1 << w) - 64'd1));
  endfunction

  function automatic logic [ValW-1:0] phase_modulus(input int ph);
    case (ph)
      0: return ValW'(1);
      1: return MaxVal;
      2: return '0;
      3: return ValW'(2);
      4: return ModReset;
      5: return ValW'($urandom_range(3, 255));
      7: return ValW'($urandom_range(3, 65535));
      default: return ValW'($urandom);
    endcase
  endfunction

  // start stays high from one word to the next when there is no gap
  task automatic send_item(input logic [ValW-1:0] b, input logic [ExpW-1:0] e,
                           input logic [ValW-1:0] want, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_base_value <= b;
    in_exponent   <= e;
    do @(posedge clk); while (busy);
    pending_powers.push_back(want);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [ValW-1:0] m);
    drain_results();
    cfg_valid   <= 1'b1;
    cfg_modulus <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    model_modulus = m;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0d",
                 $time, out_power_result);
        mismatches++;
      end else if (out_power_result !== pending_powers[0]) begin
        $display("%0t: power_result mismatch, expected %0d, actual %0d",
                 $time, pending_powers[0], out_power_result);
        mismatches++;
        void'(pending_powers.pop_front());
      end else begin
        void'(pending_powers.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallMax) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int          r;
    int          ph;
    int          n;
    int          gap;
    logic [ValW-1:0] b;
    logic [ExpW-1:0] e;
    logic [ValW-1:0] want;

    dir_rows = '{
      // reset modulus
      '{1'b0, '0, ValW'(0), ExpW'(0), 1'b1, ValW'(0)},
      '{1'b0, '0, ValW'(0), MaxExp, 1'b1, ValW'(0)},
      '{1'b0, '0, ValW'(5), ExpW'(0), 1'b1, ValW'(1)},
      '{1'b0, '0, MaxVal, ExpW'(0), 1'b1, ValW'(1)},
      '{1'b0, '0, ValW'(2), ExpW'(10), 1'b1, ValW'(1024)},
      '{1'b0, '0, ValW'(1), MaxExp, 1'b1, ValW'(1)},
      '{1'b0, '0, MaxVal, ExpW'(1), 1'b0, '0},
      '{1'b0, '0, ValW'(3), MaxExp, 1'b0, '0},
      '{1'b0, '0, MaxVal, MaxExp, 1'b0, '0},
      // modulus of one: zero exponent still gives 1
      '{1'b1, ValW'(1), ValW'(7), ExpW'(0), 1'b1, ValW'(1)},
      '{1'b0, '0, ValW'(7), ExpW'(5), 1'b1, ValW'(0)},
      '{1'b0, '0, ValW'(0), ExpW'(0), 1'b1, ValW'(0)},
      // largest modulus; unreduced base equal to it
      '{1'b1, MaxVal, MaxVal, ExpW'(1), 1'b1, ValW'(0)},
      '{1'b0, '0, ValW'(2), ExpW'(30), 1'b1, ValW'(31'h4000_0000)},
      '{1'b0, '0, ValW'(2), ExpW'(31), 1'b1, ValW'(1)},
      '{1'b0, '0, MaxVal - ValW'(1), MaxExp, 1'b0, '0},
      // zero modulus keeps the low 31 bits
      '{1'b1, ValW'(0), ValW'(2), ExpW'(31), 1'b1, ValW'(0)},
      '{1'b0, '0, ValW'(3), ExpW'(20), 1'b0, '0},
      '{1'b0, '0, MaxVal, MaxExp, 1'b0, '0},
      '{1'b1, ValW'(2), ValW'(3), ExpW'(12345), 1'b1, ValW'(1)},
      '{1'b0, '0, ValW'(31'h2AAA_AAAA), {32'h2AAA_AAAA, 31'h2AAA_AAAA}, 1'b0, '0},
      '{1'b1, ValW'(13), ValW'(26), ExpW'(1), 1'b1, ValW'(0)},
      '{1'b0, '0, ValW'(14), ExpW'(2), 1'b1, ValW'(1)},
      '{1'b0, '0, ValW'(2), ExpW'(12), 1'b1, ValW'(1)}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < NumRows; r++) begin
      if (dir_rows[r].wr_mod) begin
        write_modulus(dir_rows[r].mod_val);
      end
      want = dir_rows[r].known ? dir_rows[r].want
           : modpow_predict(dir_rows[r].base, dir_rows[r].expo, model_modulus);
      send_item(dir_rows[r].base, dir_rows[r].expo, want, $urandom_range(0, 16));
    end

    // each phase starts from a drained unit, and the sender also waits for every word
    for (ph = 0; ph < NumPhases; ph++) begin
      write_modulus(phase_modulus(ph));
      for (n = 0; n < PhaseLen; n++) begin
        b   = draw_base();
        e   = draw_exponent();
        gap = (ph % 4 == 2) ? 0 : $urandom_range(0, 16);
        send_item(b, e, modpow_predict(b, e, model_modulus), gap);
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
